FILE: hw/rtl/wfdc_pkg.sv
// Package for the wall-follow drive control: types, register codes, constants and helper functions.
`timescale 1ns / 1ps

package wfdc_pkg;

    typedef enum logic [2:0] {
        MODE_FOLLOW = 3'd0,
        MODE_SPIN   = 3'd1,
        MODE_AWAIT  = 3'd2,
        MODE_TURN   = 3'd3,
        MODE_SHUT   = 3'd4
    } t_mode;

    localparam logic [2:0] REG_WALL_TARGET  = 3'd0;
    localparam logic [2:0] REG_FRONT_LEVEL  = 3'd1;
    localparam logic [2:0] REG_TURN_LEVEL   = 3'd2;
    localparam logic [2:0] REG_SPEED_OFS    = 3'd3;
    localparam logic [2:0] REG_NEUTRAL      = 3'd4;
    localparam logic [2:0] REG_LOW_BATTERY  = 3'd5;
    localparam logic [2:0] REG_TURN_LEFT    = 3'd6;
    localparam logic [2:0] REG_TURN_RIGHT   = 3'd7;

    localparam logic [9:0]  DUTY_MAX     = 10'd512;
    localparam logic [15:0] SPIN_COUNTS  = 16'd100;
    localparam logic [15:0] TURN_COUNTS  = 16'd50;
    localparam logic [10:0] BAT_LIMIT    = 11'd1000;
    localparam logic [10:0] BAT_SAT      = 11'd2047;
    localparam logic [11:0] RECIP20      = 12'd3277;   // ceil(2^16 / 20)

    localparam logic [9:0] RST_WALL_TARGET = 10'd1;
    localparam logic [9:0] RST_FRONT_LEVEL = 10'd230;
    localparam logic [9:0] RST_TURN_LEVEL  = 10'd20;
    localparam logic [7:0] RST_SPEED_OFS   = 8'd60;
    localparam logic [8:0] RST_NEUTRAL     = 9'd256;
    localparam logic [9:0] RST_LOW_BATTERY = 10'd610;
    localparam logic [9:0] RST_TURN_LEFT   = 10'd292;
    localparam logic [9:0] RST_TURN_RIGHT  = 10'd328;
    localparam logic signed [10:0] RST_DUTY = 11'sd256;

    typedef struct packed {
        logic [9:0] wall_target;
        logic [9:0] front_trip;
        logic [9:0] turn_trip;
        logic [7:0] speed_ofs;
        logic [8:0] neutral_duty;
        logic [9:0] low_battery_level;
        logic [9:0] turn_left_duty;
        logic [9:0] turn_right_duty;
    } t_cfg;

    typedef struct packed {
        logic        kind;
        logic [9:0]  front_lit;
        logic [9:0]  front_dark;
        logic [9:0]  left_lit;
        logic [9:0]  left_dark;
        logic [9:0]  battery_level;
        logic [15:0] left_wheel_count;
        logic [15:0] right_wheel_count;
    } t_item;

    // Exact floor(x / 20) for x below 1024.
    function automatic logic [5:0] div20(input logic [9:0] x);
        logic [21:0] p;
        p = 22'(x) * 22'(RECIP20);
        return p[21:16];
    endfunction

    // Lit minus dark, floored at zero.
    function automatic logic [9:0] floor_sub(input logic [9:0] lit, input logic [9:0] dark);
        return (lit >= dark) ? (lit - dark) : 10'd0;
    endfunction

endpackage

FILE: hw/rtl/wall_follow_drive_control.sv
// Top level of the wall-follow drive control.
//
//  channel | handshake                  | payload
//  --------+----------------------------+----------------------------------------------
//  in      | i_in_valid / o_in_stall    | i_kind, i_front_*, i_left_*, i_battery_level,
//          |                            | i_left_wheel_count, i_right_wheel_count
//  out     | o_out_valid / i_out_stall  | o_left_duty, o_right_duty, o_drive_mode
//  cfg     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  One item per cycle unless the output stalls; an item passes through the input
//  register, then the single-pass compute into the result/state register.
//  Synchronous active-low reset restores register defaults, follow mode, duty 256.
//  A stalled output holds the input register; o_in_stall rises only when both are full.
//  o_cfg_ready is always high; writes take effect on the next cycle.
`timescale 1ns / 1ps

module wall_follow_drive_control (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_kind,
    input  logic [9:0]         i_front_lit,
    input  logic [9:0]         i_front_dark,
    input  logic [9:0]         i_left_lit,
    input  logic [9:0]         i_left_dark,
    input  logic [9:0]         i_battery_level,
    input  logic [15:0]        i_left_wheel_count,
    input  logic [15:0]        i_right_wheel_count,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [10:0] o_left_duty,
    output logic signed [10:0] o_right_duty,
    output logic [2:0]         o_drive_mode,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [9:0]         i_cfg_data
);

    wfdc_pkg::t_cfg  cfg;
    wfdc_pkg::t_item in_item;
    wfdc_pkg::t_item item;
    logic            item_valid;
    logic            take;

    assign in_item.kind              = i_kind;
    assign in_item.front_lit         = i_front_lit;
    assign in_item.front_dark        = i_front_dark;
    assign in_item.left_lit          = i_left_lit;
    assign in_item.left_dark         = i_left_dark;
    assign in_item.battery_level     = i_battery_level;
    assign in_item.left_wheel_count  = i_left_wheel_count;
    assign in_item.right_wheel_count = i_right_wheel_count;

    wfdc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    wfdc_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_item       (in_item),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_take       (take)
    );

    wfdc_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_take       (take),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_left_duty  (o_left_duty),
        .o_right_duty (o_right_duty),
        .o_drive_mode (o_drive_mode)
    );

endmodule

FILE: hw/rtl/wfdc_cfg.sv
// Configuration register file of the wall-follow drive control.
`timescale 1ns / 1ps

module wfdc_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [9:0]        i_cfg_data,
    output wfdc_pkg::t_cfg    o_cfg
);

    wfdc_pkg::t_cfg r_cfg;
    wfdc_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                wfdc_pkg::REG_WALL_TARGET: n_cfg.wall_target       = i_cfg_data;
                wfdc_pkg::REG_FRONT_LEVEL: n_cfg.front_trip        = i_cfg_data;
                wfdc_pkg::REG_TURN_LEVEL:  n_cfg.turn_trip         = i_cfg_data;
                wfdc_pkg::REG_SPEED_OFS:   n_cfg.speed_ofs         = i_cfg_data[7:0];
                wfdc_pkg::REG_NEUTRAL:     n_cfg.neutral_duty      = i_cfg_data[8:0];
                wfdc_pkg::REG_LOW_BATTERY: n_cfg.low_battery_level = i_cfg_data;
                wfdc_pkg::REG_TURN_LEFT:   n_cfg.turn_left_duty    = i_cfg_data;
                wfdc_pkg::REG_TURN_RIGHT:  n_cfg.turn_right_duty   = i_cfg_data;
                default:                   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wall_target       <= wfdc_pkg::RST_WALL_TARGET;
            r_cfg.front_trip        <= wfdc_pkg::RST_FRONT_LEVEL;
            r_cfg.turn_trip         <= wfdc_pkg::RST_TURN_LEVEL;
            r_cfg.speed_ofs         <= wfdc_pkg::RST_SPEED_OFS;
            r_cfg.neutral_duty      <= wfdc_pkg::RST_NEUTRAL;
            r_cfg.low_battery_level <= wfdc_pkg::RST_LOW_BATTERY;
            r_cfg.turn_left_duty    <= wfdc_pkg::RST_TURN_LEFT;
            r_cfg.turn_right_duty   <= wfdc_pkg::RST_TURN_RIGHT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: hw/rtl/wfdc_in_reg.sv
// Input register stage of the wall-follow drive control.
`timescale 1ns / 1ps

module wfdc_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  wfdc_pkg::t_item   i_item,
    output logic              o_item_valid,
    output wfdc_pkg::t_item   o_item,
    input  logic              i_take
);

    logic            r_valid;
    logic            n_valid;
    wfdc_pkg::t_item r_item;
    logic            load;

    assign o_in_stall   = r_valid && !i_take;
    assign load         = i_in_valid && !o_in_stall;
    assign n_valid      = load || (r_valid && !i_take);
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
    end

endmodule

FILE: hw/rtl/wfdc_core.sv
// Drive mode state, duty computation and result register.
`timescale 1ns / 1ps

module wfdc_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  wfdc_pkg::t_cfg           i_cfg,
    input  logic                     i_item_valid,
    input  wfdc_pkg::t_item          i_item,
    output logic                     o_take,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [10:0]       o_left_duty,
    output logic signed [10:0]       o_right_duty,
    output logic [2:0]               o_drive_mode
);

    wfdc_pkg::t_mode    r_mode,  n_mode;
    logic [15:0]        r_base,  n_base;
    logic [10:0]        r_low,   n_low;
    logic [9:0]         r_pend,  n_pend;
    logic signed [10:0] r_left,  n_left;
    logic signed [10:0] r_right, n_right;
    logic               r_out_valid;

    logic [9:0]         front_fs;
    logic [9:0]         left_fs;
    logic [9:0]         target;
    logic signed [10:0] diff;
    logic [9:0]         neg_mag;
    logic signed [10:0] err;
    logic               turn_start;
    logic [15:0]        spin_dist;
    logic [15:0]        turn_dist;
    logic               turn_end;
    logic signed [10:0] m_err;
    logic [9:0]         m_bat;
    logic [9:0]         base;
    logic signed [12:0] sum_l;
    logic signed [12:0] sum_r;
    logic [9:0]         cl_l;
    logic [9:0]         cl_r;
    logic [10:0]        low_next;
    logic               shut;

    function automatic logic [9:0] clamp_duty(input logic signed [12:0] v);
        logic [9:0] res;
        if (v < 13'sd0) begin
            res = 10'd0;
        end else if (v > $signed({3'b000, wfdc_pkg::DUTY_MAX})) begin
            res = wfdc_pkg::DUTY_MAX;
        end else begin
            res = v[9:0];
        end
        return res;
    endfunction

    assign o_take       = i_item_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid  = r_out_valid;
    assign o_left_duty  = r_left;
    assign o_right_duty = r_right;
    assign o_drive_mode = r_mode;

    always_comb begin
        front_fs = wfdc_pkg::floor_sub(i_item.front_lit, i_item.front_dark);
        left_fs  = wfdc_pkg::floor_sub(i_item.left_lit, i_item.left_dark);
        target   = (i_cfg.wall_target == 10'd0) ? 10'd1 : i_cfg.wall_target;
        diff     = $signed({1'b0, target}) - $signed({1'b0, left_fs});
        neg_mag  = 10'(-diff);
        if (diff > 11'sd0) begin
            err = diff >>> 1;
        end else begin
            err = -$signed({5'b00000, wfdc_pkg::div20(neg_mag)});
        end
        turn_start = err > $signed({1'b0, i_cfg.turn_trip});

        spin_dist = i_item.left_wheel_count - r_base;
        turn_dist = i_item.right_wheel_count - r_base;
        turn_end  = i_item.kind && (r_mode == wfdc_pkg::MODE_TURN)
                    && (turn_dist >= wfdc_pkg::TURN_COUNTS);

        m_err = turn_end ? 11'sd0 : err;
        m_bat = turn_end ? r_pend : i_item.battery_level;
        base  = 10'(i_cfg.neutral_duty) + 10'(i_cfg.speed_ofs);
        sum_l = $signed({3'b000, base}) - $signed({{2{m_err[10]}}, m_err});
        sum_r = $signed({3'b000, base}) + $signed({{2{m_err[10]}}, m_err});
        cl_l  = clamp_duty(sum_l);
        cl_r  = clamp_duty(sum_r);

        if (m_bat < i_cfg.low_battery_level) begin
            low_next = (r_low < wfdc_pkg::BAT_SAT) ? (r_low + 11'd1) : r_low;
        end else if (m_bat > i_cfg.low_battery_level) begin
            low_next = 11'd0;
        end else begin
            low_next = r_low;
        end
        shut = low_next > wfdc_pkg::BAT_LIMIT;

        n_mode  = r_mode;
        n_base  = r_base;
        n_low   = r_low;
        n_pend  = r_pend;
        n_left  = r_left;
        n_right = r_right;

        if (!i_item.kind) begin
            if ((r_mode == wfdc_pkg::MODE_FOLLOW) && (front_fs > i_cfg.front_trip)) begin
                n_left  = $signed({1'b0, base});
                n_right = $signed({2'b00, i_cfg.neutral_duty}) - $signed({3'b000, i_cfg.speed_ofs});
                n_base  = i_item.left_wheel_count;
                n_mode  = wfdc_pkg::MODE_SPIN;
            end else if ((r_mode == wfdc_pkg::MODE_FOLLOW) || (r_mode == wfdc_pkg::MODE_AWAIT)) begin
                if (turn_start) begin
                    n_left  = $signed({1'b0, i_cfg.turn_left_duty});
                    n_right = $signed({1'b0, i_cfg.turn_right_duty});
                    n_base  = i_item.right_wheel_count;
                    n_pend  = i_item.battery_level;
                    n_mode  = wfdc_pkg::MODE_TURN;
                end else begin
                    n_low = low_next;
                    if (shut) begin
                        n_mode  = wfdc_pkg::MODE_SHUT;
                        n_left  = $signed({2'b00, i_cfg.neutral_duty});
                        n_right = $signed({2'b00, i_cfg.neutral_duty});
                    end else begin
                        n_mode  = wfdc_pkg::MODE_FOLLOW;
                        n_left  = $signed({1'b0, cl_l});
                        n_right = $signed({1'b0, cl_r});
                    end
                end
            end
        end else begin
            if ((r_mode == wfdc_pkg::MODE_SPIN) && (spin_dist >= wfdc_pkg::SPIN_COUNTS)) begin
                n_mode = wfdc_pkg::MODE_AWAIT;
            end else if (turn_end) begin
                n_low = low_next;
                if (shut) begin
                    n_mode  = wfdc_pkg::MODE_SHUT;
                    n_left  = $signed({2'b00, i_cfg.neutral_duty});
                    n_right = $signed({2'b00, i_cfg.neutral_duty});
                end else begin
                    n_mode  = wfdc_pkg::MODE_FOLLOW;
                    n_left  = $signed({1'b0, cl_l});
                    n_right = $signed({1'b0, cl_r});
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= wfdc_pkg::MODE_FOLLOW;
            r_base      <= 16'd0;
            r_low       <= 11'd0;
            r_pend      <= 10'd0;
            r_left      <= wfdc_pkg::RST_DUTY;
            r_right     <= wfdc_pkg::RST_DUTY;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_mode  <= n_mode;
                r_base  <= n_base;
                r_low   <= n_low;
                r_pend  <= n_pend;
                r_left  <= n_left;
                r_right <= n_right;
            end
            if (o_take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_shut_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == wfdc_pkg::MODE_SHUT |=> r_mode == wfdc_pkg::MODE_SHUT)
        else $error("shutdown left without reset");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_take |=> $stable(r_mode) && $stable(r_left) && $stable(r_right))
        else $error("state changed without a transfer");

    a_follow_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == wfdc_pkg::MODE_FOLLOW |->
            (r_left >= 11'sd0) && (r_left <= 11'sd512)
            && (r_right >= 11'sd0) && (r_right <= 11'sd512))
        else $error("follow duty out of range");

    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_stall && !o_take |=> !r_out_valid)
        else $error("result repeated");

endmodule

FILE: test/tb_wall_follow_drive_control.sv
// Testbench for wall_follow_drive_control: directed rows, then random config phases.
`timescale 1ns / 1ps

module tb_wall_follow_drive_control;
    import wfdc_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    typedef struct packed {
        logic signed [10:0] left_duty;
        logic signed [10:0] right_duty;
        t_mode              mode;
    } t_drive_out;

    typedef struct packed {
        logic       is_reg;
        logic [2:0] reg_idx;
        logic [9:0] reg_val;
        t_item      item;
        logic       pinned;
        t_drive_out want;
    } t_step_row;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       out_stall = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [2:0] cfg_idx = '0;
    logic [9:0] cfg_val = '0;
    t_item      drv = '0;

    logic               in_stall;
    logic               out_valid;
    logic signed [10:0] left_duty;
    logic signed [10:0] right_duty;
    logic [2:0]         mode_out;
    logic               cfg_ready;

    // predictor state
    t_cfg               regs;
    t_mode              drive_mode;
    logic [15:0]        tick_base;
    logic [10:0]        low_cnt;
    logic [9:0]         held_battery;
    logic signed [10:0] duty_left;
    logic signed [10:0] duty_right;

    logic [15:0] wheel_l = 16'hFF80;
    logic [15:0] wheel_r = 16'hFFC0;
    t_drive_out  pending_duties[$];
    int          mismatches = 0;
    int          idle_pct = 11;
    int          cycles = 0;

    wall_follow_drive_control dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_stall          (in_stall),
        .i_kind              (drv.kind),
        .i_front_lit         (drv.front_lit),
        .i_front_dark        (drv.front_dark),
        .i_left_lit          (drv.left_lit),
        .i_left_dark         (drv.left_dark),
        .i_battery_level     (drv.battery_level),
        .i_left_wheel_count  (drv.left_wheel_count),
        .i_right_wheel_count (drv.right_wheel_count),
        .o_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .o_left_duty         (left_duty),
        .o_right_duty        (right_duty),
        .o_drive_mode        (mode_out),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (cfg_ready),
        .i_cfg_index         (cfg_idx),
        .i_cfg_data          (cfg_val)
    );

    always #10 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40) begin
            $display("%0t: mismatch: %s", $time, msg);
        end
    endtask

    function automatic int lit_minus_dark(input logic [9:0] lit, input logic [9:0] dark);
        return (lit > dark) ? int'(lit) - int'(dark) : 0;
    endfunction

    function automatic logic signed [10:0] clip_duty(input int v);
        if (v < 0) return '0;
        if (v > int'(DUTY_MAX)) return 11'(DUTY_MAX);
        return 11'(v);
    endfunction

    function automatic void drive_straight(input int err, input logic [9:0] bat);
        int cruise;
        cruise = int'(regs.neutral_duty) + int'(regs.speed_ofs);
        duty_left = clip_duty(cruise - err);
        duty_right = clip_duty(cruise + err);
        if (bat < regs.low_battery_level) begin
            if (low_cnt != BAT_SAT) low_cnt = low_cnt + 11'd1;
        end else if (bat > regs.low_battery_level) begin
            low_cnt = '0;
        end
        if (low_cnt > BAT_LIMIT) begin
            drive_mode = MODE_SHUT;
            duty_left = {2'b00, regs.neutral_duty};
            duty_right = {2'b00, regs.neutral_duty};
        end else begin
            drive_mode = MODE_FOLLOW;
        end
    endfunction

    function automatic void take_left(input t_item it);
        int aim, gap, err;
        aim = (regs.wall_target == '0) ? 1 : int'(regs.wall_target);
        gap = aim - lit_minus_dark(it.left_lit, it.left_dark);
        err = (gap > 0) ? gap / 2 : gap / 20;
        if (err > int'(regs.turn_trip)) begin
            duty_left = {1'b0, regs.turn_left_duty};
            duty_right = {1'b0, regs.turn_right_duty};
            tick_base = it.right_wheel_count;
            held_battery = it.battery_level;
            drive_mode = MODE_TURN;
        end else begin
            drive_straight(err, it.battery_level);
        end
    endfunction

    function automatic void advance_drive(input t_item it);
        logic [15:0] travel;
        if (!it.kind) begin
            if (drive_mode == MODE_FOLLOW) begin
                if (lit_minus_dark(it.front_lit, it.front_dark) > int'(regs.front_trip)) begin
                    duty_left = 11'(int'(regs.neutral_duty) + int'(regs.speed_ofs));
                    duty_right = 11'(int'(regs.neutral_duty) - int'(regs.speed_ofs));
                    tick_base = it.left_wheel_count;
                    drive_mode = MODE_SPIN;
                end else begin
                    take_left(it);
                end
            end else if (drive_mode == MODE_AWAIT) begin
                take_left(it);
            end
        end else if (drive_mode == MODE_SPIN) begin
            travel = it.left_wheel_count - tick_base;
            if (travel >= SPIN_COUNTS) drive_mode = MODE_AWAIT;
        end else if (drive_mode == MODE_TURN) begin
            travel = it.right_wheel_count - tick_base;
            if (travel >= TURN_COUNTS) drive_straight(0, held_battery);
        end
    endfunction

    function automatic t_step_row sens(input logic [9:0] fl, input logic [9:0] fd,
                                       input logic [9:0] ll, input logic [9:0] ld,
                                       input logic [9:0] bat, input logic [15:0] lc,
                                       input logic [15:0] rc);
        t_step_row r;
        r = '0;
        r.item = '{kind: 1'b0, front_lit: fl, front_dark: fd, left_lit: ll, left_dark: ld,
                   battery_level: bat, left_wheel_count: lc, right_wheel_count: rc};
        return r;
    endfunction

    function automatic t_step_row enc(input logic [15:0] lc, input logic [15:0] rc);
        t_step_row r;
        r = sens(10'h2AA, 10'h155, 10'h3C3, 10'h03C, 10'h3FF, lc, rc);
        r.item.kind = 1'b1;
        return r;
    endfunction

    function automatic t_step_row reg_row(input logic [2:0] idx, input logic [9:0] val);
        t_step_row r;
        r = '0;
        r.is_reg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic t_step_row pin(input t_step_row r, input logic signed [10:0] l,
                                      input logic signed [10:0] rt, input t_mode m);
        r.pinned = 1'b1;
        r.want.left_duty = l;
        r.want.right_duty = rt;
        r.want.mode = m;
        return r;
    endfunction

    function automatic int pick_reg(input int lo, input int hi);
        int r;
        r = $urandom_range(99);
        if (r < 20) return lo;
        if (r < 40) return hi;
        return int'($urandom_range(hi, lo));
    endfunction

    function automatic t_item make_item(input bit last_phase);
        t_item it;
        int aim, rd;
        bit busy;
        busy = (drive_mode == MODE_SPIN) || (drive_mode == MODE_TURN);
        it.kind = busy ? ($urandom_range(99) < 80) : ($urandom_range(99) < 15);
        if (it.kind) begin
            if ($urandom_range(99) < 8) begin
                wheel_l = 16'($urandom);
                wheel_r = 16'($urandom);
            end else begin
                wheel_l = wheel_l + 16'($urandom_range(40));
                wheel_r = wheel_r + 16'($urandom_range(40));
            end
        end
        if ($urandom_range(99) < 30) begin
            it.front_lit = 10'($urandom);
            it.front_dark = 10'($urandom);
        end else begin
            it.front_dark = 10'($urandom_range(1000));
            it.front_lit = it.front_dark + 10'($urandom_range(23));
        end
        aim = (regs.wall_target == '0) ? 1 : int'(regs.wall_target);
        if ($urandom_range(99) < 60) rd = aim + int'($urandom_range(100)) - 60;
        else rd = int'($urandom_range(1023));
        if (rd < 0) rd = 0;
        if (rd > 1023) rd = 1023;
        it.left_dark = 10'($urandom_range(1023 - rd));
        it.left_lit = it.left_dark + 10'(rd);
        if ($urandom_range(99) < 10) begin
            it.left_lit = 10'($urandom);
            it.left_dark = 10'($urandom);
        end
        it.battery_level = ($urandom_range(99) < 10) ? regs.low_battery_level : 10'($urandom);
        // keep clear of shutdown
        if (!last_phase && low_cnt > 11'd800) it.battery_level = 10'd1023;
        it.left_wheel_count = wheel_l;
        it.right_wheel_count = wheel_r;
        return it;
    endfunction

    task automatic send_item(input t_item it, input bit pinned, input t_drive_out want);
        t_drive_out nxt;
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        drv <= it;
        do @(posedge clk); while (in_stall !== 1'b0);
        advance_drive(it);
        nxt.left_duty = duty_left;
        nxt.right_duty = duty_right;
        nxt.mode = drive_mode;
        pending_duties.push_back(pinned ? want : nxt);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_duties.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
        cfg_valid <= 1'b1;
        cfg_idx <= idx;
        cfg_val <= val;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        case (idx)
            REG_WALL_TARGET: regs.wall_target = val;
            REG_FRONT_LEVEL: regs.front_trip = val;
            REG_TURN_LEVEL:  regs.turn_trip = val;
            REG_SPEED_OFS:   regs.speed_ofs = val[7:0];
            REG_NEUTRAL:     regs.neutral_duty = val[8:0];
            REG_LOW_BATTERY: regs.low_battery_level = val;
            REG_TURN_LEFT:   regs.turn_left_duty = val;
            REG_TURN_RIGHT:  regs.turn_right_duty = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_phase(input bit last_phase);
        logic [9:0] turn_lvl;
        turn_lvl = $urandom_range(1) ? 10'($urandom_range(40)) : 10'(pick_reg(0, 1023));
        settle();
        write_reg(REG_WALL_TARGET, 10'(pick_reg(1, 1023)));
        write_reg(REG_FRONT_LEVEL, last_phase ? 10'd1023 : 10'(pick_reg(0, 1023)));
        write_reg(REG_TURN_LEVEL, last_phase ? 10'd1023 : turn_lvl);
        write_reg(REG_SPEED_OFS, 10'(pick_reg(0, 1023)));
        write_reg(REG_NEUTRAL, 10'(pick_reg(0, 1023)));
        write_reg(REG_LOW_BATTERY, last_phase ? 10'd1023 : 10'(pick_reg(0, 1000)));
        write_reg(REG_TURN_LEFT, 10'(pick_reg(0, 1023)));
        write_reg(REG_TURN_RIGHT, 10'(pick_reg(0, 1023)));
    endtask

    always @(posedge clk) begin
        t_drive_out want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid === 1'b1 && !out_stall) begin
                if (pending_duties.size() == 0) begin
                    report_mismatch("result with no item outstanding");
                end else begin
                    want = pending_duties.pop_front();
                    if (left_duty !== want.left_duty)
                        report_mismatch($sformatf("left_duty got %0d want %0d",
                                                  left_duty, want.left_duty));
                    if (right_duty !== want.right_duty)
                        report_mismatch($sformatf("right_duty got %0d want %0d",
                                                  right_duty, want.right_duty));
                    if (mode_out !== want.mode)
                        report_mismatch($sformatf("drive_mode got %0d want %0d",
                                                  mode_out, want.mode));
                end
            end
            out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    initial begin
        t_step_row  plan[$];
        t_drive_out none;
        none = '0;
        regs.wall_target = RST_WALL_TARGET;
        regs.front_trip = RST_FRONT_LEVEL;
        regs.turn_trip = RST_TURN_LEVEL;
        regs.speed_ofs = RST_SPEED_OFS;
        regs.neutral_duty = RST_NEUTRAL;
        regs.low_battery_level = RST_LOW_BATTERY;
        regs.turn_left_duty = RST_TURN_LEFT;
        regs.turn_right_duty = RST_TURN_RIGHT;
        drive_mode = MODE_FOLLOW;
        tick_base = '0;
        low_cnt = '0;
        held_battery = '0;
        duty_left = RST_DUTY;
        duty_right = RST_DUTY;

        // reset defaults: cruise 316, spin 316/196
        plan.push_back(pin(sens(0, 0, 0, 0, 1023, 0, 0), 316, 316, MODE_FOLLOW));
        plan.push_back(pin(sens(0, 0, 1023, 0, 1023, 0, 0), 367, 265, MODE_FOLLOW));
        plan.push_back(pin(sens(230, 0, 0, 0, 610, 0, 0), 316, 316, MODE_FOLLOW));
        plan.push_back(pin(sens(1023, 0, 0, 0, 1023, 16'hFFF0, 0), 316, 196, MODE_SPIN));
        plan.push_back(pin(sens(0, 0, 0, 0, 1023, 0, 0), 316, 196, MODE_SPIN));
        plan.push_back(pin(enc(16'h0053, 0), 316, 196, MODE_SPIN));
        plan.push_back(pin(enc(16'h0054, 0), 316, 196, MODE_AWAIT));
        plan.push_back(pin(enc(16'h1234, 16'hFFFF), 316, 196, MODE_AWAIT));
        plan.push_back(pin(sens(1023, 0, 0, 1023, 1023, 0, 0), 316, 316, MODE_FOLLOW));
        plan.push_back(pin(enc(16'hFFFF, 16'hFFFF), 316, 316, MODE_FOLLOW));
        plan.push_back(pin(sens(0, 1023, 0, 0, 1023, 0, 0), 316, 316, MODE_FOLLOW));
        plan.push_back(reg_row(REG_WALL_TARGET, 10'd1023));
        plan.push_back(pin(sens(0, 0, 0, 0, 100, 16'hABCD, 16'hFFFF), 292, 328, MODE_TURN));
        plan.push_back(pin(sens(1023, 0, 0, 0, 1023, 0, 0), 292, 328, MODE_TURN));
        plan.push_back(pin(enc(0, 16'h0030), 292, 328, MODE_TURN));
        plan.push_back(pin(enc(0, 16'h0031), 316, 316, MODE_FOLLOW));
        plan.push_back(sens(0, 0, 1000, 0, 1023, 0, 0));
        plan.push_back(reg_row(REG_SPEED_OFS, 10'd1023));
        plan.push_back(reg_row(REG_NEUTRAL, 10'd1023));
        plan.push_back(pin(sens(0, 0, 1000, 0, 1023, 0, 0), 512, 512, MODE_FOLLOW));
        plan.push_back(pin(sens(1023, 0, 0, 0, 1023, 0, 0), 766, 256, MODE_SPIN));
        plan.push_back(pin(enc(16'd100, 0), 766, 256, MODE_AWAIT));
        plan.push_back(reg_row(REG_NEUTRAL, 10'd0));
        plan.push_back(sens(0, 0, 1000, 0, 1023, 0, 0));
        plan.push_back(pin(sens(1023, 0, 0, 0, 1023, 16'h0100, 0), 255, -255, MODE_SPIN));
        plan.push_back(enc(16'h0163, 0));
        plan.push_back(enc(16'h0164, 0));
        plan.push_back(sens(0, 0, 1000, 0, 1023, 0, 0));
        plan.push_back(reg_row(REG_SPEED_OFS, 10'd0));
        plan.push_back(pin(sens(0, 0, 1000, 0, 1023, 0, 0), 0, 11, MODE_FOLLOW));
        plan.push_back(reg_row(REG_WALL_TARGET, 10'd0));
        plan.push_back(sens(0, 0, 0, 0, 1023, 0, 0));
        plan.push_back(sens(0, 0, 21, 0, 1023, 0, 0));
        plan.push_back(sens(0, 0, 20, 0, 1023, 0, 0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[k]) begin
            if (plan[k].is_reg) begin
                settle();
                write_reg(plan[k].reg_idx, plan[k].reg_val);
            end else begin
                send_item(plan[k].item, plan[k].pinned, plan[k].want);
            end
        end

        for (int ph = 0; ph < 6; ph++) begin
            load_phase(1'b0);
            idle_pct = (ph == 2) ? 0 : 11;
            repeat (115) send_item(make_item(1'b0), 1'b0, none);
        end
        idle_pct = 11;

        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/wfdc_pkg.sv
hw/rtl/wfdc_cfg.sv
hw/rtl/wfdc_in_reg.sv
hw/rtl/wfdc_core.sv
hw/rtl/wall_follow_drive_control.sv
test/tb_wall_follow_drive_control.sv
